// File: sv/key_change_to_midi_notes_assert.svh
// Assertion macros shared by the key-change to MIDI note block.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef KEY_CHANGE_TO_MIDI_NOTES_ASSERT_SVH
`define KEY_CHANGE_TO_MIDI_NOTES_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define KCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication.
`define KCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/kcm_pkg.sv
// Shared types and constants for the key-change to MIDI note block.
// No dependencies.
package kcm_pkg;

  localparam int unsigned NumKeys = 8;

  localparam logic [3:0] NOTE_ON_HI  = 4'h9;  // 0x90 status
  localparam logic [3:0] NOTE_OFF_HI = 4'h8;  // 0x80 status
  localparam logic [6:0] NOTE_MAX    = 7'd127;

  localparam logic [6:0] BASE_NOTE_RST = 7'd48;
  localparam logic [6:0] VELOCITY_RST  = 7'd127;

  typedef enum logic [1:0] {
    REG_BASE_NOTE = 2'd0,
    REG_SCALE     = 2'd1,
    REG_VELOCITY  = 2'd2,
    REG_CHANNEL   = 2'd3
  } kcm_reg_e;

  typedef struct packed {
    logic [6:0] base_note;
    logic [1:0] scale_select;
    logic [6:0] note_velocity;
    logic [3:0] midi_channel;
  } kcm_cfg_t;

  // Prefix sums of the interval tables: offset of key k from key 0.
  typedef logic [3:0] kcm_row_t [NumKeys];
  localparam kcm_row_t KEY_OFFSET [4] = '{
    '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd12, 4'd15},  // blues
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9,  4'd11, 4'd12},  // major
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8,  4'd10, 4'd12},  // minor
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,  4'd6,  4'd7}    // chromatic
  };

  function automatic logic [6:0] kcm_note(logic [6:0] base, logic [1:0] scale,
                                          logic [2:0] key);
    logic [7:0] sum;
    sum = {1'b0, base} + {4'b0000, KEY_OFFSET[scale][key]};
    return (sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : sum[6:0];
  endfunction

endpackage

// File: sv/kcm_cfg_regs.sv
// Configuration register file for the key-change to MIDI note block.
// Depends on kcm_pkg.
module kcm_cfg_regs import kcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_wdata_i,
  output kcm_cfg_t   cfg_o
);

  kcm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (kcm_reg_e'(cfg_idx_i))
        REG_BASE_NOTE: cfg_d.base_note     = cfg_wdata_i;
        REG_SCALE:     cfg_d.scale_select  = cfg_wdata_i[1:0];
        REG_VELOCITY:  cfg_d.note_velocity = cfg_wdata_i;
        REG_CHANNEL:   cfg_d.midi_channel  = cfg_wdata_i[3:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_note     <= BASE_NOTE_RST;
      cfg_q.scale_select  <= 2'd0;
      cfg_q.note_velocity <= VELOCITY_RST;
      cfg_q.midi_channel  <= 4'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/kcm_msg_gen.sv
// Change detection and message sequencing: pending-key register, priority
// pick from key 7 down, note mapping and the output register. Uses kcm_pkg.
`include "key_change_to_midi_notes_assert.svh"

module kcm_msg_gen import kcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kcm_cfg_t    cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_keys_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_status_o,
  output logic [6:0]  out_note_o,
  output logic [6:0]  out_vel_o,
  output logic        out_last_o
);

  logic [7:0] prev_q, prev_d;
  logic [7:0] now_q, now_d;
  logic [7:0] pend_q, pend_d;
  logic       vld_q, vld_d;
  logic [7:0] status_q, status_d;
  logic [6:0] note_q, note_d;
  logic [6:0] vel_q, vel_d;
  logic       last_q, last_d;

  logic       emit, accept;
  logic [2:0] key;
  logic [7:0] pend_clr;

  // highest pending key wins
  always_comb begin
    key = 3'd0;
    for (int k = 0; k < NumKeys; k++) begin
      if (pend_q[k]) key = 3'(k);
    end
  end

  always_comb begin
    pend_clr      = pend_q;
    pend_clr[key] = 1'b0;
  end

  assign emit       = (pend_q != 8'd0) && (!vld_q || out_ready_i);
  assign in_ready_o = (pend_q == 8'd0) || (emit && (pend_clr == 8'd0));
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    prev_d   = prev_q;
    now_d    = now_q;
    pend_d   = emit ? pend_clr : pend_q;
    vld_d    = vld_q && !out_ready_i;
    status_d = status_q;
    note_d   = note_q;
    vel_d    = vel_q;
    last_d   = last_q;
    if (accept) begin
      prev_d = in_keys_i;
      now_d  = in_keys_i;
      pend_d = in_keys_i ^ prev_q;
    end
    if (emit) begin
      vld_d    = 1'b1;
      status_d = {now_q[key] ? NOTE_ON_HI : NOTE_OFF_HI, cfg_i.midi_channel};
      vel_d    = now_q[key] ? cfg_i.note_velocity : 7'd0;
      note_d   = kcm_note(cfg_i.base_note, cfg_i.scale_select, key);
      last_d   = (pend_clr == 8'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 8'd0;
      pend_q <= 8'd0;
      vld_q  <= 1'b0;
    end else begin
      prev_q <= prev_d;
      pend_q <= pend_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    status_q <= status_d;
    note_q   <= note_d;
    vel_q    <= vel_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = vld_q;
  assign out_status_o = status_q;
  assign out_note_o   = note_q;
  assign out_vel_o    = vel_q;
  assign out_last_o   = last_q;

  `KCM_ASSERT(a_no_accept_mid_run, !((pend_q != 8'd0) && !emit && in_ready_o), "accept mid-run")
  `KCM_ASSERT_NEXT(a_emit_fills, emit, vld_q, "emitted beat not held")
  `KCM_ASSERT_NEXT(a_last_marks_end, emit, last_q == $past(pend_clr == 8'd0), "tlast wrong")
  `KCM_ASSERT_NEXT(a_off_zero_vel, emit && !now_q[key], vel_q == 7'd0, "note-off velocity")

endmodule

// File: sv/key_change_to_midi_notes.sv
// Top level of the key-change to MIDI note block.
// Depends on kcm_pkg, kcm_cfg_regs and kcm_msg_gen.
//
// Each 8-bit key snapshot is compared with the one before it, and one MIDI
// note message leaves per changed key, key 7 first. A snapshot's messages
// leave one per cycle out of the single output register while m_axis_tready
// holds high; a snapshot with no change yields no beat. The next snapshot is
// taken in the same cycle that the final message of the current one moves
// into the output register, so back-to-back snapshots that each change a key
// give a gapless message stream. tlast marks the final message of a snapshot.
// Configuration must only be written while no messages are outstanding.
module key_change_to_midi_notes import kcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_states
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] status_byte, [14:8] note_number,
                                      // [21:15] velocity, [23:22] zero
  output logic        m_axis_tlast    // last_message
);

  kcm_cfg_t   cfg;
  logic [7:0] status;
  logic [6:0] note;
  logic [6:0] vel;

  kcm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kcm_msg_gen u_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_keys_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (status),
    .out_note_o   (note),
    .out_vel_o    (vel),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, vel, note, status};

endmodule
